// ----- sv/demand_paging_lru_translator_macros.svh -----
// ----------------------------------------------------------------------------
// demand paging lru translator assertion macros
// shared concurrent check forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef DEMAND_PAGING_LRU_TRANSLATOR_MACROS_SVH
`define DEMAND_PAGING_LRU_TRANSLATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DPLT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DPLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dplt_pkg.sv -----
// ----------------------------------------------------------------------------
// dplt_pkg
// beat types, status codes and register indexes of the paging translator
// ----------------------------------------------------------------------------
`default_nettype none

package dplt_pkg;

  // configuration port widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USER_FRAME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_BASE         = 1'd1;

  // register reset values
  localparam logic [3:0] FIRST_USER_FRAME_RST = 4'd2;
  localparam logic [6:0] SEC_BASE_RST         = 7'd0;

  // request modes
  localparam logic MODE_TRANSLATE = 1'b0;
  localparam logic MODE_FLUSH     = 1'b1;

  // result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_FREE    = 3'd1;
  localparam logic [2:0] ST_EVICT   = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_FLUSH   = 3'd4;

  // request beat
  typedef struct packed {
    logic       mode;
    logic [7:0] virtual_address;
  } req_t;

  // result beat
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] physical_address;
    logic [3:0] frame_index;
    logic [4:0] evicted_page;
    logic [7:0] sec_frame;
    logic       load_valid;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/demand_paging_lru_translator.sv -----
// ----------------------------------------------------------------------------
// demand_paging_lru_translator
// virtual to physical page translation with lru frame replacement
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  dplt_pkg::req_t
//  rsp      out        rsp_valid / rsp_ready  dplt_pkg::rsp_t
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  flush: idle, finish; invalid page: div, ofs, finish; hit: div, ofs, hit, finish
//  fault: div, ofs, then a walk of frames from first_user_frame (up to
//  NUM_FRAMES - first_user_frame frames), map, finish; one frame table read per cycle
//  one request in flight; the next is taken once the result sits in rsp
//  reset clears page and frame valid bits at once, no clearing pass
//  a stalled rsp holds the next result in the finish state
`default_nettype none

module demand_paging_lru_translator #(
  parameter int NUM_PAGES   = 32,
  parameter int NUM_FRAMES  = 16,
  parameter int FRAME_BYTES = 4,
  parameter int SEC_FRAMES  = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire dplt_pkg::req_t                 req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output dplt_pkg::rsp_t                      rsp,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dplt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dplt_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "demand_paging_lru_translator_macros.svh"

  localparam int PW    = (NUM_PAGES > 2) ? $clog2(NUM_PAGES) : 1;
  localparam int FW    = (NUM_FRAMES > 2) ? $clog2(NUM_FRAMES) : 1;
  localparam int OW    = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
  // ceiling reciprocal, exact for 8-bit dividends
  localparam int RECIP = (65536 + FRAME_BYTES - 1) / FRAME_BYTES;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_OFS, S_HIT, S_SCAN, S_MAP, S_FIN
  } state_t;

  typedef struct packed {
    logic [PW-1:0] owner;
    logic [31:0]   stamp;
  } frame_entry_t;

  state_t state;

  // configuration registers
  logic [3:0] first_user_frame;
  logic [6:0] sec_base;

  // valid bits and tick
  logic [NUM_PAGES-1:0]  page_valid;
  logic [NUM_FRAMES-1:0] frame_busy;
  logic [31:0]           tick;

  // per-item working registers
  logic [7:0]    va;
  logic [7:0]    quot;
  logic [OW-1:0] offset;
  logic [FW-1:0] rd_idx;
  logic [31:0]   min_stamp;
  logic [FW-1:0] min_idx;
  logic [PW-1:0] min_owner;
  logic [FW-1:0] sel_frame;
  logic [PW-1:0] sel_owner;
  logic          evict;
  dplt_pkg::rsp_t res;

  // memories
  logic [FW-1:0] page_frame_mem [NUM_PAGES];
  frame_entry_t  frame_mem      [NUM_FRAMES];
  logic [FW-1:0] pf_rdata;
  frame_entry_t  fe_rdata;
  logic [FW-1:0] fe_raddr;
  logic          pf_we;
  logic          fe_we;
  logic [FW-1:0] fe_waddr;
  frame_entry_t  fe_wdata;

  // derived values
  logic [23:0]   quot_prod;
  logic [14:0]   page_base;
  logic [PW-1:0] page;
  logic [FW-1:0] fuf_f;
  logic [31:0]   tick_inc;
  logic          scan_first;
  logic          scan_take;
  logic          scan_last;
  logic [8:0]    sec_sum;
  logic [FW-1:0] hit_frame;
  logic [NUM_PAGES-1:0] evict_mask;
  logic [NUM_PAGES-1:0] map_mask;
  logic          flush_take;
  dplt_pkg::rsp_t flush_res;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // page and offset split by reciprocal multiply
  assign quot_prod = 24'(va) * 24'(RECIP);
  assign page_base = 15'(quot) * 15'(FRAME_BYTES);
  assign page      = PW'(quot);
  assign fuf_f     = FW'(first_user_frame);
  assign tick_inc  = (tick == '1) ? tick : tick + 32'd1;
  assign sec_sum   = 9'(sec_base) + 9'(page);
  assign hit_frame = pf_rdata;

  // page valid update masks for a mapping
  assign evict_mask = evict ? (NUM_PAGES'(1) << sel_owner) : '0;
  assign map_mask   = NUM_PAGES'(1) << page;

  // flush beat taken on the request side
  assign flush_take = req_valid && req_ready && (req.mode == dplt_pkg::MODE_FLUSH);

  // result beat of a flush
  always_comb begin
    flush_res        = '0;
    flush_res.status = dplt_pkg::ST_FLUSH;
  end

  // lru walk compare
  assign scan_first = (rd_idx == fuf_f);
  assign scan_take  = scan_first || (fe_rdata.stamp < min_stamp);
  assign scan_last  = (rd_idx == FW'(NUM_FRAMES - 1));

  // frame table read address and write port
  always_comb begin
    fe_raddr = fuf_f;
    if (state == S_SCAN) begin
      fe_raddr = rd_idx + FW'(1);
    end
  end

  always_comb begin
    pf_we    = 1'b0;
    fe_we    = 1'b0;
    fe_waddr = sel_frame;
    fe_wdata.owner = page;
    fe_wdata.stamp = tick_inc;
    case (state)
      S_HIT: begin
        fe_we    = 1'b1;
        fe_waddr = hit_frame;
      end
      S_MAP: begin
        pf_we = 1'b1;
        fe_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // page to frame memory
  always_ff @(posedge clk) begin
    if (pf_we) begin
      page_frame_mem[page] <= sel_frame;
    end
    pf_rdata <= page_frame_mem[page];
  end

  // frame owner and stamp memory
  always_ff @(posedge clk) begin
    if (fe_we) begin
      frame_mem[fe_waddr] <= fe_wdata;
    end
    fe_rdata <= frame_mem[fe_raddr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_user_frame <= dplt_pkg::FIRST_USER_FRAME_RST;
      sec_base         <= dplt_pkg::SEC_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dplt_pkg::CFG_FIRST_USER_FRAME: first_user_frame <= cfg_data[3:0];
        dplt_pkg::CFG_SEC_BASE:         sec_base         <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer, valid bits, tick and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      page_valid <= '0;
      frame_busy <= '0;
      tick       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            va <= req.virtual_address;
            if (req.mode == dplt_pkg::MODE_FLUSH) begin
              page_valid <= '0;
              frame_busy <= '0;
              tick       <= '0;
              res        <= flush_res;
              state      <= S_FIN;
            end else begin
              res   <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quot  <= quot_prod[23:16];
          state <= S_OFS;
        end
        S_OFS: begin
          offset <= OW'(15'(va) - page_base);
          if (32'(quot) >= NUM_PAGES) begin
            res.status <= dplt_pkg::ST_INVALID;
            state      <= S_FIN;
          end else if (page_valid[page]) begin
            state <= S_HIT;
          end else if (32'(first_user_frame) >= NUM_FRAMES) begin
            res.status <= dplt_pkg::ST_INVALID;
            state      <= S_FIN;
          end else begin
            rd_idx <= fuf_f;
            state  <= S_SCAN;
          end
        end
        S_HIT: begin
          tick                 <= tick_inc;
          res.status           <= dplt_pkg::ST_HIT;
          res.frame_index      <= 4'(hit_frame);
          res.physical_address <= 6'(32'(hit_frame) * FRAME_BYTES + 32'(offset));
          state                <= S_FIN;
        end
        S_SCAN: begin
          if (!frame_busy[rd_idx]) begin
            sel_frame <= rd_idx;
            evict     <= 1'b0;
            state     <= S_MAP;
          end else begin
            if (scan_take) begin
              min_stamp <= fe_rdata.stamp;
              min_idx   <= rd_idx;
              min_owner <= fe_rdata.owner;
            end
            if (scan_last) begin
              sel_frame <= scan_take ? rd_idx : min_idx;
              sel_owner <= scan_take ? fe_rdata.owner : min_owner;
              evict     <= 1'b1;
              state     <= S_MAP;
            end else begin
              rd_idx <= rd_idx + FW'(1);
            end
          end
        end
        S_MAP: begin
          page_valid            <= (page_valid & ~evict_mask) | map_mask;
          frame_busy[sel_frame] <= 1'b1;
          tick                  <= tick_inc;
          res.status           <= evict ? dplt_pkg::ST_EVICT : dplt_pkg::ST_FREE;
          res.frame_index      <= 4'(sel_frame);
          res.physical_address <= 6'(32'(sel_frame) * FRAME_BYTES + 32'(offset));
          res.evicted_page     <= evict ? 5'(sel_owner) : 5'd0;
          res.sec_frame        <= sec_sum[7:0];
          res.load_valid       <= (32'(sec_sum) < SEC_FRAMES);
          state                <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a hit must land on a frame that is in use
  `DPLT_ASSERT_SAME(a_hit_frame_busy, state == S_HIT, frame_busy[hit_frame], "hit on free frame")

  // the lru walk never looks below the first user frame
  `DPLT_ASSERT_SAME(a_scan_range, state == S_SCAN, rd_idx >= fuf_f, "walk below first user frame")

  // mapping leaves the new page valid
  `DPLT_ASSERT_NEXT(a_map_valid, state == S_MAP, page_valid[$past(page)], "mapped page not valid")

  // the tick only moves back on a flush
  `DPLT_ASSERT_NEXT(a_tick_mono, !flush_take, tick >= $past(tick), "tick went back")

endmodule

`default_nettype wire
